[src/cau_pkg.sv]
`default_nettype none

package cau_pkg;

	// Fixed field width on the ports and default fixed-point format
	localparam int DATA_W   = 32;
	localparam int DEF_FRAC = 16;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [DATA_W-1:0] a_re;
		logic signed [DATA_W-1:0] a_im;
		logic signed [DATA_W-1:0] b_re;
		logic signed [DATA_W-1:0] b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_re;
		logic signed [DATA_W-1:0] res_im;
		logic                     div_zero;
		logic                     overflow;
	} cau_out_t;

endpackage

`default_nettype wire

[src/complex_arithmetic_unit.sv]
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed fixed point (WIDTH bits, FRAC_BITS fraction bits).
// Input channel in_valid/in_ready/in_data carries mode and both operands;
// output channel out_valid/out_ready/out_data carries both result parts,
// the divide-by-zero flag and the saturation flag. Only the low WIDTH bits
// of each operand part are used; results are sign-extended to 32 bits.
// Pipeline, default Q16.16: input register, product stage, combine
// stage, divider setup, one restoring-divider stage per quotient bit
// (WIDTH+1 of them), then the output register. Both divide quotients
// are computed side by side, one bit per stage, so the divider chain
// sets the latency. Throughput is one beat per cycle in every mode when
// not stalled. Each stage holds its beat only while the next one is full
// and stalled, so a stalled receiver backs up the pipe stage by stage and
// empty stages still take new beats. Reset clears all valid bits; no data
// is stored between beats.
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int WIDTH     = DATA_W,
	parameter int FRAC_BITS = DEF_FRAC
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire cau_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output cau_out_t      out_data
);

	localparam int W  = WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;          // product width
	localparam int MW = 2 * W + 3;      // multiply combine width
	localparam int NW = 2 * W + F;      // divider remainder width
	localparam int CW = 3 * W + F + 1;  // divider compare width
	localparam int QW = W + 1;          // quotient bits kept
	localparam int ND = W + 2;          // divider setup plus bit stages
	localparam int NS = W + 6;          // total stages

	localparam logic [W-1:0]  MAX_W  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MIN_W  = {1'b1, {(W-1){1'b0}}};
	localparam logic [QW-1:0] MAXQ_P = {2'b00, {(W-1){1'b1}}};
	localparam logic [QW-1:0] MAXQ_N = {2'b01, {(W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]    mode;
		logic          dz;
		logic [W-1:0]  fin_re;
		logic [W-1:0]  fin_im;
		logic          fin_ovf;
		logic          neg_re;
		logic          neg_im;
		logic          big_re;
		logic          big_im;
		logic [PW-1:0] den;
		logic [NW-1:0] r_re;
		logic [NW-1:0] r_im;
		logic [QW-1:0] q_re;
		logic [QW-1:0] q_im;
	} dstg_t;

	// Stage valids and stall chain
	logic [NS-1:0] vld_q;
	logic [NS:0]   adv;

	always_comb begin
		adv[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NS-1];

	// Stage 1: capture operands, pre-add for the three-multiply form
	logic [1:0]            mode_s1;
	logic signed [W-1:0]   ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [W:0]     sa_s1, sb_s1;
	logic signed [W-1:0]   ar_in, ai_in, br_in, bi_in;

	assign ar_in = in_data.a_re[W-1:0];
	assign ai_in = in_data.a_im[W-1:0];
	assign br_in = in_data.b_re[W-1:0];
	assign bi_in = in_data.b_im[W-1:0];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mode_s1 <= in_data.mode;
			ar_s1   <= ar_in;
			ai_s1   <= ai_in;
			br_s1   <= br_in;
			bi_s1   <= bi_in;
			sa_s1   <= (W+1)'(ar_in) + (W+1)'(ai_in);
			sb_s1   <= (W+1)'(br_in) + (W+1)'(bi_in);
		end
	end

	// Stage 2: all products, plus add/subtract
	logic [1:0]             mode_s2;
	logic signed [W:0]      addre_s2, addim_s2;
	logic signed [PW-1:0]   p_s2, q_s2, x_s2, y_s2, d1_s2, d2_s2;
	logic signed [PW+1:0]   s_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mode_s2 <= mode_s1;
			if (mode_t'(mode_s1) == MODE_SUB) begin
				addre_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
				addim_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
			end else begin
				addre_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
				addim_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
			end
			p_s2  <= PW'(ar_s1) * PW'(br_s1);
			q_s2  <= PW'(ai_s1) * PW'(bi_s1);
			x_s2  <= PW'(ai_s1) * PW'(br_s1);
			y_s2  <= PW'(ar_s1) * PW'(bi_s1);
			d1_s2 <= PW'(br_s1) * PW'(br_s1);
			d2_s2 <= PW'(bi_s1) * PW'(bi_s1);
			s_s2  <= (PW+2)'(sa_s1) * (PW+2)'(sb_s1);
		end
	end

	// Stage 3: finish add/sub/multiply results, form divide numerators
	logic signed [MW-1:0] mre, mim, mre_sh, mim_sh;
	logic signed [PW:0]   nre, nim;
	logic [W-1:0]         fre, fim;
	logic                 fovf;
	logic                 mre_ok, mim_ok, are_ok, aim_ok;

	always_comb begin
		mre    = MW'(p_s2) - MW'(q_s2);
		mim    = MW'(s_s2) - MW'(p_s2) - MW'(q_s2);
		mre_sh = mre >>> F;
		mim_sh = mim >>> F;
		nre    = (PW+1)'(p_s2) + (PW+1)'(q_s2);
		nim    = (PW+1)'(x_s2) - (PW+1)'(y_s2);
		mre_ok = (&mre_sh[MW-1:W-1]) || !(|mre_sh[MW-1:W-1]);
		mim_ok = (&mim_sh[MW-1:W-1]) || !(|mim_sh[MW-1:W-1]);
		are_ok = addre_s2[W] == addre_s2[W-1];
		aim_ok = addim_s2[W] == addim_s2[W-1];
		fre    = '0;
		fim    = '0;
		fovf   = 1'b0;
		if (mode_t'(mode_s2) == MODE_MUL) begin
			fre  = mre_ok ? mre_sh[W-1:0] : (mre_sh[MW-1] ? MIN_W : MAX_W);
			fim  = mim_ok ? mim_sh[W-1:0] : (mim_sh[MW-1] ? MIN_W : MAX_W);
			fovf = !mre_ok || !mim_ok;
		end else begin
			fre  = are_ok ? addre_s2[W-1:0] : (addre_s2[W] ? MIN_W : MAX_W);
			fim  = aim_ok ? addim_s2[W-1:0] : (addim_s2[W] ? MIN_W : MAX_W);
			fovf = !are_ok || !aim_ok;
		end
	end

	logic [1:0]    mode_s3;
	logic [W-1:0]  fre_s3, fim_s3;
	logic          fovf_s3, nre_neg_s3, nim_neg_s3;
	logic [PW-1:0] nre_mag_s3, nim_mag_s3, den_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mode_s3    <= mode_s2;
			fre_s3     <= fre;
			fim_s3     <= fim;
			fovf_s3    <= fovf;
			nre_neg_s3 <= nre[PW];
			nim_neg_s3 <= nim[PW];
			nre_mag_s3 <= nre[PW] ? PW'(-nre) : nre[PW-1:0];
			nim_mag_s3 <= nim[PW] ? PW'(-nim) : nim[PW-1:0];
			den_s3     <= PW'(d1_s2) + PW'(d2_s2);
		end
	end

	// Divider setup: scale numerators, flag quotients too large to track
	dstg_t         dstg_s [0:ND-1];
	logic [NW-1:0] rre0, rim0;

	assign rre0 = NW'(nre_mag_s3) << F;
	assign rim0 = NW'(nim_mag_s3) << F;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			dstg_s[0].mode    <= mode_s3;
			dstg_s[0].dz      <= den_s3 == '0;
			dstg_s[0].fin_re  <= fre_s3;
			dstg_s[0].fin_im  <= fim_s3;
			dstg_s[0].fin_ovf <= fovf_s3;
			dstg_s[0].neg_re  <= nre_neg_s3;
			dstg_s[0].neg_im  <= nim_neg_s3;
			dstg_s[0].big_re  <= CW'(rre0) >= (CW'(den_s3) << QW);
			dstg_s[0].big_im  <= CW'(rim0) >= (CW'(den_s3) << QW);
			dstg_s[0].den     <= den_s3;
			dstg_s[0].r_re    <= rre0;
			dstg_s[0].r_im    <= rim0;
			dstg_s[0].q_re    <= '0;
			dstg_s[0].q_im    <= '0;
		end
	end

	// Restoring divider, one quotient bit per stage, MSB first
	for (genvar k = 1; k < ND; k++) begin : g_div
		localparam int B = ND - 1 - k;
		logic [CW-1:0] dsh;
		logic          ge_re, ge_im;
		dstg_t         nxt;

		assign dsh   = CW'(dstg_s[k-1].den) << B;
		assign ge_re = CW'(dstg_s[k-1].r_re) >= dsh;
		assign ge_im = CW'(dstg_s[k-1].r_im) >= dsh;

		always_comb begin
			nxt         = dstg_s[k-1];
			nxt.r_re    = ge_re ? dstg_s[k-1].r_re - NW'(dsh) : dstg_s[k-1].r_re;
			nxt.r_im    = ge_im ? dstg_s[k-1].r_im - NW'(dsh) : dstg_s[k-1].r_im;
			nxt.q_re[B] = ge_re;
			nxt.q_im[B] = ge_im;
		end

		always_ff @(posedge clk) begin
			if (adv[3+k]) begin
				dstg_s[k] <= nxt;
			end
		end
	end

	// Output stage: sign and saturate quotients, select by mode
	dstg_t        dl;
	logic [W-1:0] ore, oim;
	logic         ovf_re, ovf_im, odz, oovf;

	always_comb begin
		dl     = dstg_s[ND-1];
		ovf_re = dl.big_re || (dl.neg_re ? dl.q_re > MAXQ_N : dl.q_re > MAXQ_P);
		ovf_im = dl.big_im || (dl.neg_im ? dl.q_im > MAXQ_N : dl.q_im > MAXQ_P);
		odz    = 1'b0;
		if (mode_t'(dl.mode) != MODE_DIV) begin
			ore  = dl.fin_re;
			oim  = dl.fin_im;
			oovf = dl.fin_ovf;
		end else if (dl.dz) begin
			ore  = MAX_W;
			oim  = MAX_W;
			oovf = 1'b0;
			odz  = 1'b1;
		end else begin
			if (ovf_re) begin
				ore = dl.neg_re ? MIN_W : MAX_W;
			end else begin
				ore = dl.neg_re ? W'(-dl.q_re) : dl.q_re[W-1:0];
			end
			if (ovf_im) begin
				oim = dl.neg_im ? MIN_W : MAX_W;
			end else begin
				oim = dl.neg_im ? W'(-dl.q_im) : dl.q_im[W-1:0];
			end
			oovf = ovf_re || ovf_im;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			out_data.res_re   <= DATA_W'($signed(ore));
			out_data.res_im   <= DATA_W'($signed(oim));
			out_data.div_zero <= odz;
			out_data.overflow <= oovf;
		end
	end

	// Checks
	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while receiver is ready");

	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_zero |-> !out_data.overflow)
		else $error("divide by zero also flagged overflow");

	a_dz_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_zero |-> out_data.res_re == out_data.res_im)
		else $error("divide by zero parts differ");

endmodule

`default_nettype wire
